FILE: sv/acal_pkg.sv
`timescale 1ns / 1ps
package acal_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CH_W        = 2;
    localparam int NUM_CH      = 4;
    localparam int NUM_REGS    = 2 * NUM_CH;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int ADDR_W      = REG_IDX_W + 2;
    localparam int APB_DATA_W  = 32;
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TUSER_W     = 8;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

    // register map: minima first, then maxima, each in channel order
    localparam logic [REG_IDX_W-1:0] REG_MIN_BASE = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MAX_BASE = REG_IDX_W'(NUM_CH);

    localparam logic [SAMPLE_BITS-1:0] MIN_RESET [NUM_CH] = '{
        SAMPLE_BITS'(8), SAMPLE_BITS'(8), SAMPLE_BITS'(7), SAMPLE_BITS'(7)
    };
    localparam logic [SAMPLE_BITS-1:0] MAX_RESET [NUM_CH] = '{
        SAMPLE_BITS'(3169), SAMPLE_BITS'(3169), SAMPLE_BITS'(3169), SAMPLE_BITS'(31)
    };

    typedef enum logic [1:0] {
        CLAMP_NONE,
        CLAMP_ZERO,
        CLAMP_FULL
    } clamp_t;

    typedef struct packed {
        logic                   valid;
        logic [CH_W-1:0]        channel;
        clamp_t                 clamp;
        logic [SAMPLE_BITS-1:0] span;
        logic [SAMPLE_BITS-1:0] rem;
        logic [SAMPLE_BITS-1:0] num;
        logic [SAMPLE_BITS-1:0] quo;
    } div_beat_t;

endpackage

FILE: sv/acal_front.sv
`timescale 1ns / 1ps
module acal_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [acal_pkg::CH_W-1:0]        in_channel,
    input  logic [acal_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic [acal_pkg::SAMPLE_BITS-1:0] cal_lo,
    input  logic [acal_pkg::SAMPLE_BITS-1:0] cal_hi,
    output acal_pkg::div_beat_t              beat_out
);
    import acal_pkg::*;

    logic                   s0_valid_reg;
    logic [CH_W-1:0]        s0_channel_reg;
    clamp_t                 s0_clamp_reg;
    logic [SAMPLE_BITS-1:0] s0_span_reg;
    logic [SAMPLE_BITS-1:0] s0_diff_reg;

    clamp_t                   clamp_next;
    logic [2*SAMPLE_BITS-1:0] numer;
    div_beat_t                beat_next;
    div_beat_t                beat_reg;

    always_comb begin
        if (cal_hi <= cal_lo) begin
            clamp_next = CLAMP_ZERO;
        end else if (in_sample <= cal_lo) begin
            clamp_next = CLAMP_ZERO;
        end else if (in_sample >= cal_hi) begin
            clamp_next = CLAMP_FULL;
        end else begin
            clamp_next = CLAMP_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (advance) begin
            s0_valid_reg <= in_valid;
        end
        if (advance) begin
            s0_channel_reg <= in_channel;
            s0_clamp_reg   <= clamp_next;
            s0_span_reg    <= cal_hi - cal_lo;
            s0_diff_reg    <= in_sample - cal_lo;
        end
    end

    // times full scale: shift up by the sample width, subtract once
    assign numer = {s0_diff_reg, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, s0_diff_reg};

    always_comb begin
        beat_next.valid   = s0_valid_reg;
        beat_next.channel = s0_channel_reg;
        beat_next.clamp   = s0_clamp_reg;
        beat_next.span    = s0_span_reg;
        beat_next.rem     = numer[2*SAMPLE_BITS-1:SAMPLE_BITS];
        beat_next.num     = numer[SAMPLE_BITS-1:0];
        beat_next.quo     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (advance) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

FILE: sv/acal_div_cell.sv
`timescale 1ns / 1ps
module acal_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  acal_pkg::div_beat_t beat_in,
    output acal_pkg::div_beat_t beat_out
);
    import acal_pkg::*;

    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   span_ext;
    logic [SAMPLE_BITS:0]   reduced;
    logic                   q_bit;
    div_beat_t              beat_next;
    div_beat_t              beat_reg;

    // one restoring step: bring down the next numerator bit, try the span
    assign trial    = {beat_in.rem, beat_in.num[SAMPLE_BITS-1]};
    assign span_ext = {1'b0, beat_in.span};
    assign q_bit    = (trial >= span_ext);
    assign reduced  = trial - span_ext;

    always_comb begin
        beat_next     = beat_in;
        beat_next.rem = q_bit ? reduced[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        beat_next.num = {beat_in.num[SAMPLE_BITS-2:0], 1'b0};
        beat_next.quo = {beat_in.quo[SAMPLE_BITS-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (advance) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

FILE: sv/adc_linear_calibration_remap_unit.sv
`timescale 1ns / 1ps
// Two-point calibration of four joystick ADC channels. Each input beat carries
// a raw sample (s_tdata) and its channel (s_tuser); the result beat returns
// (raw - min) * 4095 / (max - min), truncated, with 0 at or below min, 4095 at
// or above max, and 0 when max <= min. Minima sit at 0x00..0x0C and maxima at
// 0x10..0x1C on the APB port; write them only while no beat is in flight.
// One beat is taken every cycle unless the output stalls; the pipeline is made of
// the subtract and multiply stages, a chain of twelve divider cells (one quotient
// bit per cell) and the output register. All stages advance together whenever the
// output register is empty or drained, so s_tready follows m_tready.
module adc_linear_calibration_remap_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [acal_pkg::TDATA_W-1:0]      s_tdata,   // raw_sample, zero pad
    input  logic [acal_pkg::TUSER_W-1:0]      s_tuser,   // channel, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [acal_pkg::TDATA_W-1:0]      m_tdata,   // scaled, zero pad
    output logic [acal_pkg::TUSER_W-1:0]      m_tuser,   // channel_out, zero pad
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [acal_pkg::ADDR_W-1:0]       paddr,
    input  logic [acal_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [acal_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import acal_pkg::*;

    logic [SAMPLE_BITS-1:0] min_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] max_reg [NUM_CH];

    logic                   out_valid_reg;
    logic [CH_W-1:0]        out_channel_reg;
    logic [SAMPLE_BITS-1:0] out_scaled_reg;
    logic [SAMPLE_BITS-1:0] scaled_next;

    logic                   advance;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   cfg_idx;
    logic [CH_W-1:0]        in_channel;
    div_beat_t              beats [SAMPLE_BITS+1];

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                min_reg[i] <= MIN_RESET[i];
                max_reg[i] <= MAX_RESET[i];
            end
        end else if (cfg_wr) begin
            if (cfg_idx < REG_MAX_BASE) begin
                min_reg[CH_W'(cfg_idx - REG_MIN_BASE)] <= pwdata[SAMPLE_BITS-1:0];
            end else begin
                max_reg[CH_W'(cfg_idx - REG_MAX_BASE)] <= pwdata[SAMPLE_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (cfg_idx < REG_MAX_BASE) begin
            prdata = APB_DATA_W'(min_reg[CH_W'(cfg_idx - REG_MIN_BASE)]);
        end else begin
            prdata = APB_DATA_W'(max_reg[CH_W'(cfg_idx - REG_MAX_BASE)]);
        end
    end

    // hold every stage while the output beat waits
    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = advance;
    assign in_channel = s_tuser[CH_W-1:0];

    acal_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_tvalid),
        .in_channel (in_channel),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .cal_lo     (min_reg[in_channel]),
        .cal_hi     (max_reg[in_channel]),
        .beat_out   (beats[0])
    );

    for (genvar g = 0; g < SAMPLE_BITS; g++) begin : g_cell
        acal_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .beat_in  (beats[g]),
            .beat_out (beats[g+1])
        );
    end

    always_comb begin
        case (beats[SAMPLE_BITS].clamp)
            CLAMP_NONE: scaled_next = beats[SAMPLE_BITS].quo;
            CLAMP_ZERO: scaled_next = '0;
            CLAMP_FULL: scaled_next = FULL_SCALE;
            default:    scaled_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= beats[SAMPLE_BITS].valid;
        end
        if (advance) begin
            out_channel_reg <= beats[SAMPLE_BITS].channel;
            out_scaled_reg  <= scaled_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_scaled_reg);
    assign m_tuser  = TUSER_W'(out_channel_reg);

endmodule

FILE: sv/acal_checker.sv
`timescale 1ns / 1ps
module acal_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [acal_pkg::TDATA_W-1:0]      m_tdata,
    input logic [acal_pkg::TUSER_W-1:0]      m_tuser
);
    import acal_pkg::*;

    // no result beat may appear in the cycle after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a draining output side never blocks the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // padding above the result fields stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> SAMPLE_BITS) == '0 && (m_tuser >> CH_W) == '0)
        else $error("nonzero padding in result beat");

endmodule

bind adc_linear_calibration_remap_unit acal_checker u_acal_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import acal_pkg::*;

    typedef enum logic [CH_W-1:0] {CH_X1, CH_Y1, CH_X2, CH_Y2} chan_e;

    typedef enum int {
        REG_MIN_X1, REG_MIN_Y1, REG_MIN_X2, REG_MIN_Y2,
        REG_MAX_X1, REG_MAX_Y1, REG_MAX_X2, REG_MAX_Y2
    } cal_reg_e;

    typedef struct packed {
        logic [CH_W-1:0]        chan;
        logic [SAMPLE_BITS-1:0] scaled;
    } remap_beat_t;

    typedef struct packed {
        chan_e                  chan;
        logic [SAMPLE_BITS-1:0] raw;
        logic                   known;
        logic [SAMPLE_BITS-1:0] want;
    } dir_row_t;

    localparam logic [SAMPLE_BITS-1:0] TOP_CODE = {SAMPLE_BITS{1'b1}};
    localparam int PIPE_DEPTH   = 15;
    localparam int DIR_ROWS     = 22;
    localparam int DIR_SPLIT    = 10;
    localparam int RAND_PHASES  = 6;
    localparam int RAND_PER_PHASE = 140;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;     // raw_sample [11:0], zero pad
    logic [TUSER_W-1:0]    s_tuser;     // channel [1:0], zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;     // scaled [11:0], zero pad
    logic [TUSER_W-1:0]    m_tuser;     // channel_out [1:0], zero pad
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // typed-in expectation that travels with the beat on s_*
    logic                   beat_known;
    logic [SAMPLE_BITS-1:0] beat_want;

    logic [SAMPLE_BITS-1:0] cal_min [NUM_CH];
    logic [SAMPLE_BITS-1:0] cal_max [NUM_CH];

    remap_beat_t pending_q [$];
    int samples_sent;
    int results_seen;
    int mismatch_count;
    int settings_count;
    int send_idle_pct;
    int recv_idle_pct;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // reset calibration
        '{CH_X1, 12'd0,    1'b1, 12'd0},
        '{CH_X1, 12'd8,    1'b1, 12'd0},
        '{CH_X1, 12'd3169, 1'b1, 12'd4095},
        '{CH_Y1, 12'd4095, 1'b1, 12'd4095},
        '{CH_Y1, 12'd9,    1'b0, 12'd0},
        '{CH_X2, 12'hAAA,  1'b0, 12'd0},
        '{CH_X2, 12'h555,  1'b0, 12'd0},
        '{CH_Y2, 12'd19,   1'b0, 12'd0},
        '{CH_Y2, 12'd31,   1'b1, 12'd4095},
        '{CH_Y2, 12'd30,   1'b0, 12'd0},
        // empty, inverted, full and one-code spans
        '{CH_X1, 12'd100,  1'b1, 12'd0},
        '{CH_X1, 12'd4095, 1'b1, 12'd0},
        '{CH_Y1, 12'd2048, 1'b1, 12'd0},
        '{CH_Y1, 12'd4095, 1'b1, 12'd0},
        '{CH_X2, 12'd0,    1'b1, 12'd0},
        '{CH_X2, 12'd1,    1'b1, 12'd1},
        '{CH_X2, 12'd4094, 1'b1, 12'd4094},
        '{CH_X2, 12'd4095, 1'b1, 12'd4095},
        '{CH_Y2, 12'd4094, 1'b1, 12'd0},
        '{CH_Y2, 12'd4095, 1'b1, 12'd4095},
        '{CH_Y2, 12'h800,  1'b1, 12'd0},
        '{CH_Y1, 12'd0,    1'b1, 12'd0}
    };

    adc_linear_calibration_remap_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [SAMPLE_BITS-1:0] calib_remap(logic [SAMPLE_BITS-1:0] sample,
                                                           logic [SAMPLE_BITS-1:0] lo,
                                                           logic [SAMPLE_BITS-1:0] hi);
        int unsigned num;
        int unsigned span;
        if (hi <= lo || sample <= lo)
            return '0;
        if (sample >= hi)
            return TOP_CODE;
        num  = (32'(sample) - 32'(lo)) * 32'(TOP_CODE);
        span = 32'(hi) - 32'(lo);
        return SAMPLE_BITS'(num / span);
    endfunction

    // mostly uniform, with a share landing right around the span edges
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(chan_e ch);
        int base;
        int r;
        r = $urandom_range(7);
        if (r < 2) begin
            base = (r == 0) ? int'(cal_min[ch]) : int'(cal_max[ch]);
            base = base + int'($urandom_range(2)) - 1;
            if (base < 0)
                base = 0;
            if (base > int'(TOP_CODE))
                base = int'(TOP_CODE);
            return SAMPLE_BITS'(base);
        end
        return SAMPLE_BITS'($urandom());
    endfunction

    always @(posedge aclk)
        m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin : check_results
        remap_beat_t want_b;
        remap_beat_t got_b;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want_b.chan   = s_tuser[CH_W-1:0];
                want_b.scaled = beat_known ? beat_want :
                                calib_remap(s_tdata[SAMPLE_BITS-1:0],
                                            cal_min[s_tuser[CH_W-1:0]],
                                            cal_max[s_tuser[CH_W-1:0]]);
                pending_q.push_back(want_b);
            end
            if (m_tvalid && m_tready) begin
                got_b.chan   = m_tuser[CH_W-1:0];
                got_b.scaled = m_tdata[SAMPLE_BITS-1:0];
                results_seen++;
                if (pending_q.size() == 0) begin
                    $error("unexpected result beat: channel_out %0d scaled %0d",
                           got_b.chan, got_b.scaled);
                    mismatch_count++;
                end else begin
                    want_b = pending_q.pop_front();
                    if (got_b.chan !== want_b.chan) begin
                        $error("channel_out: expected %0d, got %0d", want_b.chan, got_b.chan);
                        mismatch_count++;
                    end
                    if (got_b.scaled !== want_b.scaled) begin
                        $error("scaled: expected %0d, got %0d", want_b.scaled, got_b.scaled);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic send_sample(chan_e ch, logic [SAMPLE_BITS-1:0] raw,
                               logic known, logic [SAMPLE_BITS-1:0] want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= TDATA_W'(raw);
        s_tuser    <= TUSER_W'(ch);
        beat_known <= known;
        beat_want  <= want;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        samples_sent++;
    endtask

    // hold the input until every accepted beat has come back
    task automatic wait_all_remapped();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_seen != samples_sent)
            @(posedge aclk);
    endtask

    task automatic write_cal(cal_reg_e idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (idx >= REG_MAX_X1)
            cal_max[idx - REG_MAX_X1] = value[SAMPLE_BITS-1:0];
        else
            cal_min[idx] = value[SAMPLE_BITS-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        // read back the register just written
        if (prdata !== APB_DATA_W'(value[SAMPLE_BITS-1:0])) begin
            $error("prdata: expected %0d, got %0d", value[SAMPLE_BITS-1:0], prdata);
            mismatch_count++;
        end
    endtask

    task automatic randomize_cal();
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        for (int c = 0; c < NUM_CH; c++) begin
            lo = SAMPLE_BITS'($urandom());
            hi = SAMPLE_BITS'($urandom());
            case ($urandom_range(7))
                0: begin
                    lo = '0;
                    hi = TOP_CODE;
                end
                1: hi = lo;
                2: if (lo < hi) {lo, hi} = {hi, lo};
                3: hi = (lo > TOP_CODE - 16) ? TOP_CODE :
                        lo + SAMPLE_BITS'($urandom_range(1, 16));
                default: if (lo > hi) {lo, hi} = {hi, lo};
            endcase
            // junk above bit 11 must be dropped by the register
            write_cal(cal_reg_e'(c), {20'($urandom()), lo});
            write_cal(cal_reg_e'(c + NUM_CH), {20'($urandom()), hi});
        end
        settings_count++;
    endtask

    initial begin
        chan_e ch;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        m_tready   <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        beat_known <= 1'b0;
        beat_want  <= '0;
        cal_min = '{12'd8, 12'd8, 12'd7, 12'd7};
        cal_max = '{12'd3169, 12'd3169, 12'd3169, 12'd31};
        samples_sent   = 0;
        results_seen   = 0;
        mismatch_count = 0;
        settings_count = 1;
        send_idle_pct  = 28;
        recv_idle_pct  = 79;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DIR_SPLIT) begin
                wait_all_remapped();
                write_cal(REG_MIN_X1, 32'hFFFF_F064);
                write_cal(REG_MAX_X1, 32'd100);
                write_cal(REG_MIN_Y1, 32'h0000_0FFF);
                write_cal(REG_MAX_Y1, 32'hFFFF_F000);
                write_cal(REG_MIN_X2, 32'd0);
                write_cal(REG_MAX_X2, 32'd4095);
                write_cal(REG_MIN_Y2, 32'd4094);
                write_cal(REG_MAX_Y2, 32'hA5A5_AFFF);
                settings_count++;
            end
            send_sample(dir_rows[i].chan, dir_rows[i].raw, dir_rows[i].known,
                        dir_rows[i].want);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            wait_all_remapped();
            randomize_cal();
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if ($urandom_range(99) == 0)
                    wait_all_remapped();
                ch = chan_e'($urandom_range(NUM_CH - 1));
                send_sample(ch, pick_sample(ch), 1'b0, '0);
            end
        end

        wait_all_remapped();
        repeat (PIPE_DEPTH + 5) @(posedge aclk);
        if (pending_q.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_q.size());
            mismatch_count++;
        end
        $display("Remapped %0d samples on all four channels under %0d calibration settings,",
                 results_seen, settings_count);
        $display("including empty, inverted, full and one-code spans and both clamps.");
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
sv/acal_pkg.sv
sv/acal_front.sv
sv/acal_div_cell.sv
sv/adc_linear_calibration_remap_unit.sv
sv/acal_checker.sv
bench/tb.sv
